/* rtl/core/rtpm_pkg.sv */
// Shared types, codes and a helper function of the prefix-match route table.
`timescale 1ns / 1ps

package rtpm_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_ROUTE = 3'd1,
    ST_DUP      = 3'd2,
    ST_EVICTED  = 3'd3,
    ST_MISSED   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } state_e;

  // One route as held in a cell.
  typedef struct packed {
    logic        valid;
    logic [31:0] net;
    logic [31:0] mask;
    logic [5:0]  plen;
    logic [31:0] hop;
    logic [3:0]  iface;
  } entry_t;

  // Operation held steady in front of every cell while the sweep runs.
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] mask;
  } bcast_t;

  // Partial answer handed from one cell to the next.
  typedef struct packed {
    logic        hit;
    logic        best_valid;
    logic [5:0]  best_plen;
    logic [31:0] best_hop;
    logic [3:0]  best_iface;
  } carry_t;

  // Table update applied at the end of an item.
  typedef struct packed {
    logic ins;
    logic del;
  } cmd_t;

  // Count of one-bits, summed a nibble at a time.
  function automatic logic [5:0] ones_count(input logic [31:0] v);
    logic [5:0] total;
    logic [2:0] nib;
    total = '0;
    for (int n = 0; n < 8; n++) begin
      nib = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
      total = total + 6'(nib);
    end
    return total;
  endfunction

endpackage

/* rtl/core/route_table_prefix_match.sv */
// Top level of the IPv4 longest-prefix-match route table.
`timescale 1ns / 1ps

// Channel  Handshake                Payload
// input    in_valid_i / in_ready_o  opcode_i, address_i, net_mask_i, hop_in_i, iface_in_i
// output   out_valid_o / out_ready_i status_o, hop_out_o, iface_out_o
//
// For each item, the operation is broadcast to a chain of TABLE_ENTRIES cells
// and a partial answer walks the chain one cell per cycle. The table update
// and the result are written together in the final state, which waits for the
// output register. The next item can be taken in the cycle after that write;
// the block takes no new item while one is still in the chain.
// Reset clears all valid bits at once; no sweep follows it.
// A new item is taken while a finished result still waits in the output
// register; only the final cycle waits for that register to free up.

module route_table_prefix_match
  import rtpm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int IFACE_COUNT   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] address_i,
  input  logic [31:0] net_mask_i,
  input  logic [31:0] hop_in_i,
  input  logic [3:0]  iface_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] hop_out_o,
  output logic [3:0]  iface_out_o
);

  localparam int CntW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(TABLE_ENTRIES - 1);
  localparam logic [8:0] IfaceMax = 9'(IFACE_COUNT - 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  opcode_e         op_q;
  bcast_t          bcast_q;
  entry_t          new_q;
  logic            accept;
  logic            commit;
  cmd_t            cmd;
  carry_t          last_carry;
  logic            out_valid_q;
  status_e         status_q, status_d;
  logic [31:0]     hop_q, hop_d;
  logic [3:0]      iface_q, iface_d;
  logic [3:0]      iface_sat;

  entry_t entries [TABLE_ENTRIES];
  carry_t carries [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_vec;

  assign accept = in_valid_i && in_ready_o;
  assign commit = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Interface numbers past the last port are clamped to it.
  assign iface_sat = ({5'd0, iface_in_i} >= 9'(IFACE_COUNT)) ? IfaceMax[3:0] : iface_in_i;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SWEEP;
          cnt_d   = '0;
        end
      end
      S_SWEEP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and the table update at the last cycle.
  always_comb begin
    in_ready_o = 1'b0;
    cmd        = '0;
    unique case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_SWEEP: in_ready_o = 1'b0;
      S_DONE: begin
        if (commit) begin
          cmd.ins = (op_q == OP_ADD) && !last_carry.hit;
          cmd.del = (op_q == OP_REMOVE) && last_carry.hit;
        end
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // The operation is captured once and held in front of the chain.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= opcode_e'(opcode_i);
      bcast_q.addr <= address_i;
      bcast_q.mask <= net_mask_i;
      new_q.valid  <= 1'b1;
      new_q.net    <= address_i;
      new_q.mask   <= net_mask_i;
      new_q.plen   <= ones_count(net_mask_i);
      new_q.hop    <= hop_in_i;
      new_q.iface  <= iface_sat;
    end
  end

  // The chain: cell 0 holds the newest route and takes new routes from the
  // captured route register; the oldest cell pulls in an empty slot on a remove.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    carry_t carry_in;

    if (i == 0) begin : g_head
      assign left_e   = new_q;
      assign carry_in = '0;
    end else begin : g_body
      assign left_e   = entries[i-1];
      assign carry_in = carries[i-1];
    end

    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = entries[i+1];
    end

    rtpm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bcast_i (bcast_q),
      .carry_i (carry_in),
      .left_i  (left_e),
      .right_i (right_e),
      .cmd_i   (cmd),
      .entry_o (entries[i]),
      .carry_o (carries[i])
    );

    assign valid_vec[i] = entries[i].valid;
  end

  assign last_carry = carries[TABLE_ENTRIES-1];

  // Result of the item from the settled answer at the end of the chain.
  always_comb begin
    status_d = ST_OK;
    hop_d    = '0;
    iface_d  = '0;
    unique case (op_q)
      OP_LOOKUP: begin
        if (last_carry.best_valid) begin
          hop_d   = last_carry.best_hop;
          iface_d = last_carry.best_iface;
        end else begin
          status_d = ST_NO_ROUTE;
        end
      end
      OP_ADD: begin
        if (last_carry.hit) begin
          status_d = ST_DUP;
        end else if (valid_vec[TABLE_ENTRIES-1]) begin
          status_d = ST_EVICTED;
        end
      end
      OP_REMOVE: begin
        if (!last_carry.hit) begin
          status_d = ST_MISSED;
        end
      end
      OP_NONE: status_d = ST_OK;
      default: status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q <= status_d;
      hop_q    <= hop_d;
      iface_q  <= iface_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign hop_out_o   = hop_q;
  assign iface_out_o = iface_q;

  // Valid slots always form a run starting at the newest slot.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, valid_vec} + {{TABLE_ENTRIES{1'b0}}, 1'b1}))
    else $error("valid slots are not contiguous");

  // An accepted item always starts the sweep.
  a_accept_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SWEEP))
    else $error("accepted item did not start the sweep");

  // A committed insert leaves a valid route in the newest slot.
  a_insert_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> (valid_vec[0] && out_valid_q))
    else $error("insert did not fill the newest slot");

endmodule

/* rtl/core/rtpm_cell.sv */
// One slot of the route table chain with its compare logic.
`timescale 1ns / 1ps

module rtpm_cell
  import rtpm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  bcast_t bcast_i,
  input  carry_t carry_i,
  input  entry_t left_i,
  input  entry_t right_i,
  input  cmd_t   cmd_i,
  output entry_t entry_o,
  output carry_t carry_o
);

  logic        valid_q, valid_d;
  logic [31:0] net_q, net_d;
  logic [31:0] mask_q, mask_d;
  logic [5:0]  plen_q, plen_d;
  logic [31:0] hop_q, hop_d;
  logic [3:0]  iface_q, iface_d;
  carry_t      carry_q, carry_d;
  logic        exact;
  logic        pmatch;

  assign exact  = valid_q && (net_q == bcast_i.addr) && (mask_q == bcast_i.mask);
  assign pmatch = valid_q && ((bcast_i.addr & mask_q) == net_q);

  // Keep the earlier candidate on a tie, so the newest route wins.
  always_comb begin
    carry_d     = carry_i;
    carry_d.hit = carry_i.hit | exact;
    if (pmatch && (!carry_i.best_valid || (carry_i.best_plen < plen_q))) begin
      carry_d.best_valid = 1'b1;
      carry_d.best_plen  = plen_q;
      carry_d.best_hop   = hop_q;
      carry_d.best_iface = iface_q;
    end
  end

  // An insert shifts every slot one place older; a remove pulls the slots
  // from the hit onward one place newer.
  always_comb begin
    valid_d = valid_q;
    net_d   = net_q;
    mask_d  = mask_q;
    plen_d  = plen_q;
    hop_d   = hop_q;
    iface_d = iface_q;
    if (cmd_i.ins) begin
      valid_d = left_i.valid;
      net_d   = left_i.net;
      mask_d  = left_i.mask;
      plen_d  = left_i.plen;
      hop_d   = left_i.hop;
      iface_d = left_i.iface;
    end else if (cmd_i.del && carry_q.hit) begin
      valid_d = right_i.valid;
      net_d   = right_i.net;
      mask_d  = right_i.mask;
      plen_d  = right_i.plen;
      hop_d   = right_i.hop;
      iface_d = right_i.iface;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      carry_q <= '0;
    end else begin
      valid_q <= valid_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    net_q   <= net_d;
    mask_q  <= mask_d;
    plen_q  <= plen_d;
    hop_q   <= hop_d;
    iface_q <= iface_d;
  end

  assign entry_o = '{valid: valid_q, net: net_q, mask: mask_q, plen: plen_q,
                     hop: hop_q, iface: iface_q};
  assign carry_o = carry_q;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the longest-prefix-match route table.
`timescale 1ns / 1ps

module testbench
  import rtpm_pkg::*;
();

  localparam int TABLE_DEPTH   = 16;
  localparam int IFACE_LIMIT   = 16;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int DIRECTED_ROWS = 22;
  // The tail wait after the drain leaves room for about twice the time that one
  // item takes from acceptance to its result.
  localparam int DRAIN_CYCLES  = 2 * (TABLE_DEPTH + 2);
  // The receiver's long hold-off, in cycles.
  localparam int LONG_HOLD     = 300;
  // Cycles without any handshake before the run is declared hung. The slowest
  // correct stretch is the long hold-off plus one item's gaps and latency.
  localparam int STALL_LIMIT   = 5000;

  // One operation as offered on the input channel.
  typedef struct packed {
    opcode_e     op;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [3:0]  iface;
  } route_req_t;

  // One answer as it leaves on the output channel.
  typedef struct packed {
    status_e     status;
    logic [31:0] hop;
    logic [3:0]  iface;
  } route_ans_t;

  // A route as this testbench tracks it; slot 0 is the newest.
  typedef struct packed {
    logic        valid;
    logic [31:0] net;
    logic [31:0] mask;
    logic [5:0]  plen;
    logic [31:0] hop;
    logic [3:0]  iface;
  } route_t;

  // A directed row. When known_answer is set, the answer is typed in here;
  // otherwise it comes from the shadow table.
  typedef struct packed {
    route_req_t req;
    logic       known_answer;
    route_ans_t ans;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  opcode_i;
  logic [31:0] address_i;
  logic [31:0] net_mask_i;
  logic [31:0] hop_in_i;
  logic [3:0]  iface_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [31:0] hop_out_o;
  logic [3:0]  iface_out_o;

  route_t     shadow_routes [TABLE_DEPTH];
  route_ans_t pending_answers [$];
  int         mismatches;
  int         idle_cycles;
  logic       hold_off_req;
  logic       send_burst;
  logic       recv_burst;

  // The directed part: empty-table answers, duplicates, the default route,
  // nested prefixes, a host route with a zero next hop, a mask with holes,
  // network bits outside the mask, a tie between equal prefix lengths, and
  // removal hits and misses.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0},
      1'b1, '{ST_NO_ROUTE, 32'h0, 4'h0}},
    '{'{OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF},
      1'b1, '{ST_MISSED, 32'h0, 4'h0}},
    '{'{OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF},
      1'b1, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_ADD,    32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF},
      1'b1, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_ADD,    32'h0000_0000, 32'h0000_0000, 32'h0000_1234, 4'h3},
      1'b1, '{ST_DUP, 32'h0, 4'h0}},
    '{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'h0000_0000, 4'h0},
      1'b1, '{ST_OK, 32'hFFFF_FFFF, 4'hF}},
    '{'{OP_ADD,    32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 4'h1},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_ADD,    32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 4'h2},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_LOOKUP, 32'h0A01_0203, 32'h0000_0000, 32'h0000_0000, 4'h0},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_ADD,    32'h0A01_0203, 32'hFFFF_FFFF, 32'h0000_0000, 4'h0},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_LOOKUP, 32'h0A01_0203, 32'h0000_0000, 32'h0000_0000, 4'h0},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_ADD,    32'h1200_3400, 32'hFF00_FF00, 32'hC0A8_0001, 4'h4},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_LOOKUP, 32'h12AB_34CD, 32'h0000_0000, 32'h0000_0000, 4'h0},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_ADD,    32'h0A0A_0A0A, 32'hFFFF_0000, 32'hC0A8_0002, 4'h5},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_LOOKUP, 32'h0A0A_0A0A, 32'h0000_0000, 32'h0000_0000, 4'h0},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_ADD,    32'h0000_0000, 32'h0000_0001, 32'h1111_1111, 4'h6},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_ADD,    32'h0000_0000, 32'h0000_0002, 32'h2222_2222, 4'h7},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_REMOVE, 32'h0A01_0000, 32'hFFFF_0000, 32'h0000_0000, 4'h0},
      1'b1, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_REMOVE, 32'h0A01_0000, 32'hFFFF_0000, 32'h0000_0000, 4'h0},
      1'b1, '{ST_MISSED, 32'h0, 4'h0}},
    '{'{OP_LOOKUP, 32'h0A01_0204, 32'h0000_0000, 32'h0000_0000, 4'h0},
      1'b0, '{ST_OK, 32'h0, 4'h0}},
    '{'{OP_LOOKUP, 32'h0B00_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF},
      1'b0, '{ST_OK, 32'h0, 4'h0}}
  };

  route_table_prefix_match #(
    .TABLE_ENTRIES(TABLE_DEPTH),
    .IFACE_COUNT  (IFACE_LIMIT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .address_i  (address_i),
    .net_mask_i (net_mask_i),
    .hop_in_i   (hop_in_i),
    .iface_in_i (iface_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .hop_out_o  (hop_out_o),
    .iface_out_o(iface_out_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Slot of the route with exactly this network and mask, or -1.
  function automatic int find_shadow_route(input logic [31:0] net, input logic [31:0] mask);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (shadow_routes[i].valid && shadow_routes[i].net == net &&
          shadow_routes[i].mask == mask) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Valid slots always form a prefix of the table, so this is also the
  // index of the first free slot.
  function automatic int shadow_route_count();
    int n;
    n = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (shadow_routes[i].valid) begin
        n++;
      end
    end
    return n;
  endfunction

  // Applies one operation to the shadow table and returns the answer that the
  // block must give for it.
  function automatic route_ans_t apply_route_op(input route_req_t req);
    route_ans_t ans;
    int         best;
    int         slot;
    logic [3:0] ifc;
    ans  = '{status: ST_OK, hop: 32'h0, iface: 4'h0};
    best = -1;
    case (req.op)
      OP_LOOKUP: begin
        // Longest prefix wins; a strict compare keeps the newest on a tie.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (shadow_routes[i].valid &&
              (req.addr & shadow_routes[i].mask) == shadow_routes[i].net) begin
            if (best < 0 || shadow_routes[i].plen > shadow_routes[best].plen) begin
              best = i;
            end
          end
        end
        if (best < 0) begin
          ans.status = ST_NO_ROUTE;
        end else begin
          ans.hop   = shadow_routes[best].hop;
          ans.iface = shadow_routes[best].iface;
        end
      end
      OP_ADD: begin
        if (find_shadow_route(req.addr, req.mask) >= 0) begin
          ans.status = ST_DUP;
        end else begin
          if (shadow_routes[TABLE_DEPTH-1].valid) begin
            ans.status = ST_EVICTED;
          end
          for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
            shadow_routes[i] = shadow_routes[i-1];
          end
          ifc = (int'(req.iface) >= IFACE_LIMIT) ? 4'(IFACE_LIMIT - 1) : req.iface;
          shadow_routes[0] = '{valid: 1'b1, net: req.addr, mask: req.mask,
                               plen: 6'($countones(req.mask)), hop: req.hop,
                               iface: ifc};
        end
      end
      OP_REMOVE: begin
        slot = find_shadow_route(req.addr, req.mask);
        if (slot < 0) begin
          ans.status = ST_MISSED;
        end else begin
          for (int i = slot; i < TABLE_DEPTH - 1; i++) begin
            shadow_routes[i] = shadow_routes[i+1];
          end
          shadow_routes[TABLE_DEPTH-1].valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  // Draws a random operation. Most of them aim at routes already in the
  // table, so lookups hit nested prefixes and removes find their target;
  // the rest use random or partly random values.
  function automatic route_req_t random_request();
    route_req_t req;
    int         pick;
    int         count;
    int         slot;
    int         plen;
    logic [31:0] noise;
    req   = '{op: OP_LOOKUP, addr: $urandom, mask: $urandom, hop: $urandom,
              iface: 4'($urandom_range(0, 15))};
    pick  = $urandom_range(0, 99);
    count = shadow_route_count();
    slot  = (count > 0) ? $urandom_range(0, count - 1) : 0;
    noise = $urandom;
    if (pick < 5) begin
      req.op = OP_NONE;
    end else if (pick < 42) begin
      req.op = OP_ADD;
      case ($urandom_range(0, 9))
        0: begin
          // Same network and mask as a stored route.
          if (count > 0) begin
            req.addr = shadow_routes[slot].net;
            req.mask = shadow_routes[slot].mask;
          end
        end
        1: begin
          // Random network and mask, usually with bits outside the mask.
        end
        2: begin
          // One extra bit past /8 gives many routes of equal length that
          // overlap, so ties between them are decided by age.
          req.mask = 32'hFF00_0000 | (32'h1 << $urandom_range(0, 23));
          req.addr = 32'h0A00_0000;
        end
        default: begin
          plen     = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32)
                                               : $urandom_range(8, 32);
          req.mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
          req.addr = ($urandom_range(0, 3) == 0) ? noise : {8'h0A, noise[23:0]};
          req.addr = req.addr & req.mask;
        end
      endcase
    end else if (pick < 58) begin
      req.op = OP_REMOVE;
      if (count > 0 && $urandom_range(0, 3) != 0) begin
        req.addr = shadow_routes[slot].net;
        req.mask = shadow_routes[slot].mask;
      end
    end else begin
      req.op = OP_LOOKUP;
      if (count > 0 && $urandom_range(0, 6) != 0) begin
        // An address inside the chosen route, random elsewhere.
        req.addr = (shadow_routes[slot].net & shadow_routes[slot].mask) |
                   (noise & ~shadow_routes[slot].mask);
      end else if ($urandom_range(0, 1) == 0) begin
        req.addr = {8'h0A, noise[23:0]};
      end
    end
    return req;
  endfunction

  // Offers one item after a random gap and returns at the edge that accepts
  // it. Valid stays high after acceptance, so back-to-back items never lower
  // and raise it in the same time step.
  task automatic offer_request(input route_req_t req);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 39) == 0) begin
      send_burst = !send_burst;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= req.op;
    address_i  <= req.addr;
    net_mask_i <= req.mask;
    hop_in_i   <= req.hop;
    iface_in_i <= req.iface;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Lowers valid and waits until every answer owed has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  // Stimulus: reset, the directed rows, then the random items.
  initial begin : stimulus
    route_req_t req;
    route_ans_t ans;
    mismatches   = 0;
    hold_off_req = 1'b0;
    send_burst   = 1'b0;
    recv_burst   = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_routes[i] = '0;
    end
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    opcode_i   = OP_LOOKUP;
    address_i  = 32'h0;
    net_mask_i = 32'h0;
    hop_in_i   = 32'h0;
    iface_in_i = 4'h0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer_request(directed_rows[r].req);
      ans = apply_route_op(directed_rows[r].req);
      pending_answers.push_back(directed_rows[r].known_answer ? directed_rows[r].ans : ans);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Once, the receiver stops taking results for a long stretch while the
      // sender keeps pushing, so the block fills up and stalls its input.
      if (n == 300) begin
        hold_off_req = 1'b1;
        send_burst   = 1'b1;
      end
      // Twice, the sender goes quiet until the block has nothing in flight.
      if (n == 600 || n == 950) begin
        wait_for_drain();
      end
      req = random_request();
      offer_request(req);
      pending_answers.push_back(apply_route_op(req));
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("route_table_prefix_match regression: pass");
    end else begin
      $display("route_table_prefix_match regression: fail");
    end
    $finish;
  end

  // Result side: random stalls on ready, each result checked against the
  // oldest answer still owed.
  initial begin : result_sink
    int         stall;
    route_ans_t want;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = recv_burst ? 0 : $urandom_range(0, 19);
      end
      if ($urandom_range(0, 39) == 0) begin
        recv_burst = !recv_burst;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_answers.size() == 0) begin
        $display("%0t: result with none expected: status %0h hop %0h iface %0h",
                 $time, status_o, hop_out_o, iface_out_o);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        compare_field("status", 32'(want.status), 32'(status_o));
        compare_field("hop", want.hop, hop_out_o);
        compare_field("iface", 32'(want.iface), 32'(iface_out_o));
      end
    end
  end

  // Hang detection: any stretch this long without a handshake on either
  // channel means the block has locked up.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("route_table_prefix_match regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule
